// ===== src/pdas_pkg.sv =====
package pdas_pkg;

	localparam logic [7:0] START_DATA = 8'h02;
	localparam logic [7:0] START_LAST = 8'h03;

	localparam logic [15:0] MAX_LENGTH_RESET = 16'd2048;

	localparam logic [1:0] KIND_PAYLOAD = 2'd0;
	localparam logic [1:0] KIND_END     = 2'd1;
	localparam logic [1:0] KIND_CONTROL = 2'd2;

	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_MISMATCH = 2'd1;
	localparam logic [1:0] STATUS_TOO_LONG = 2'd2;

	typedef enum logic [6:0] {
		PH_IDLE    = 7'b0000001,
		PH_SEQ     = 7'b0000010,
		PH_LEN_LO  = 7'b0000100,
		PH_LEN_HI  = 7'b0001000,
		PH_PAYLOAD = 7'b0010000,
		PH_SUM_LO  = 7'b0100000,
		PH_SUM_HI  = 7'b1000000
	} phase_t;

	typedef struct packed {
		logic        valid;
		logic [1:0]  kind;
		logic [7:0]  data_byte;
		logic        is_last_packet;
		logic [7:0]  sequence_res;
		logic [15:0] payload_length;
		logic [1:0]  status;
	} result_t;

endpackage

// ===== src/pdas_fsm.sv =====
module pdas_fsm (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic [7:0]       rx_byte,
	input  logic [15:0]      max_length,
	output pdas_pkg::result_t res
);

	pdas_pkg::phase_t phase_q, phase_d;
	logic        type_is_last_q, type_is_last_d;
	logic [7:0]  seq_hold_q, seq_hold_d;
	logic [15:0] length_hold_q, length_hold_d;
	logic [15:0] bytes_left_q, bytes_left_d;
	logic [15:0] running_sum_q, running_sum_d;
	logic [7:0]  sum_low_hold_q, sum_low_hold_d;
	logic [15:0] len_full;
	logic [15:0] left_dec;
	logic [15:0] got_sum;

	assign len_full = {rx_byte, length_hold_q[7:0]};
	assign left_dec = bytes_left_q - 16'd1;
	assign got_sum  = {rx_byte, sum_low_hold_q};

	always_comb begin
		phase_d        = phase_q;
		type_is_last_d = type_is_last_q;
		seq_hold_d     = seq_hold_q;
		length_hold_d  = length_hold_q;
		bytes_left_d   = bytes_left_q;
		running_sum_d  = running_sum_q;
		sum_low_hold_d = sum_low_hold_q;

		res                = '0;
		res.is_last_packet = type_is_last_q;
		res.sequence_res   = seq_hold_q;
		res.payload_length = length_hold_q;

		case (phase_q)
			pdas_pkg::PH_SEQ: begin
				seq_hold_d = rx_byte;
				phase_d    = pdas_pkg::PH_LEN_LO;
			end
			pdas_pkg::PH_LEN_LO: begin
				length_hold_d = {8'd0, rx_byte};
				phase_d       = pdas_pkg::PH_LEN_HI;
			end
			pdas_pkg::PH_LEN_HI: begin
				length_hold_d = len_full;
				if (len_full > max_length) begin
					phase_d            = pdas_pkg::PH_IDLE;
					res.valid          = 1'b1;
					res.kind           = pdas_pkg::KIND_END;
					res.payload_length = len_full;
					res.status         = pdas_pkg::STATUS_TOO_LONG;
				end else begin
					running_sum_d = '0;
					bytes_left_d  = len_full;
					phase_d       = (len_full == 16'd0) ? pdas_pkg::PH_SUM_LO
					                                    : pdas_pkg::PH_PAYLOAD;
				end
			end
			pdas_pkg::PH_PAYLOAD: begin
				running_sum_d = running_sum_q + {8'd0, rx_byte};
				bytes_left_d  = left_dec;
				if (left_dec == 16'd0)
					phase_d = pdas_pkg::PH_SUM_LO;
				res.valid     = 1'b1;
				res.kind      = pdas_pkg::KIND_PAYLOAD;
				res.data_byte = rx_byte;
			end
			pdas_pkg::PH_SUM_LO: begin
				sum_low_hold_d = rx_byte;
				phase_d        = pdas_pkg::PH_SUM_HI;
			end
			pdas_pkg::PH_SUM_HI: begin
				phase_d    = pdas_pkg::PH_IDLE;
				res.valid  = 1'b1;
				res.kind   = pdas_pkg::KIND_END;
				res.status = (got_sum == running_sum_q) ? pdas_pkg::STATUS_OK
				                                        : pdas_pkg::STATUS_MISMATCH;
			end
			default: begin
				// idle: look for a start byte, report anything else
				phase_d = pdas_pkg::PH_IDLE;
				if (rx_byte == pdas_pkg::START_DATA || rx_byte == pdas_pkg::START_LAST) begin
					type_is_last_d = (rx_byte == pdas_pkg::START_LAST);
					phase_d        = pdas_pkg::PH_SEQ;
				end else begin
					res                = '0;
					res.valid          = 1'b1;
					res.kind           = pdas_pkg::KIND_CONTROL;
					res.data_byte      = rx_byte;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= pdas_pkg::PH_IDLE;
			type_is_last_q <= 1'b0;
			seq_hold_q     <= '0;
			length_hold_q  <= '0;
			bytes_left_q   <= '0;
			running_sum_q  <= '0;
			sum_low_hold_q <= '0;
		end else if (step) begin
			phase_q        <= phase_d;
			type_is_last_q <= type_is_last_d;
			seq_hold_q     <= seq_hold_d;
			length_hold_q  <= length_hold_d;
			bytes_left_q   <= bytes_left_d;
			running_sum_q  <= running_sum_d;
			sum_low_hold_q <= sum_low_hold_d;
		end
	end

endmodule

// ===== src/packet_deframer_additive_sum.sv =====
// Length-prefixed packet deframer with a 16-bit additive checksum.
// Input channel (in_valid / in_stall / rx_byte) carries one received byte
// per transfer. Output channel (out_valid / out_stall and the result fields)
// carries zero or one result per byte: a payload byte, a packet end with its
// status, or a control character seen outside a packet.
// Configuration: pulse cfg_wr_en with cfg_wr_data to set max_length
// (2048 after reset); write it only while no byte is in flight.
// A byte passes through the input register, then the result register, which
// presents its result. Throughput, set by the single state update per byte
// in the framing state machine, is one byte per cycle while the receiver
// does not hold out_stall on a waiting result.
// When the receiver holds out_stall, the result register holds its value and
// the input register holds one more byte; in_stall rises only once both are
// occupied, so a byte is taken in the same cycle a result leaves.
// Reset (arst_n low) empties both registers, returns the framer to idle and
// clears its header, length and checksum state.
module packet_deframer_additive_sum (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic [7:0]  data_byte,
	output logic        is_last_packet,
	output logic [7:0]  sequence_res,
	output logic [15:0] payload_length,
	output logic [1:0]  status
);

	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              out_free;
	logic              advance;
	logic [15:0]       max_length_q;
	pdas_pkg::result_t res;
	pdas_pkg::result_t out_q;

	// result slot is free when empty or being drained this cycle
	assign out_free = !out_q.valid || !out_stall;
	assign advance  = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;

	// input register: take a new byte whenever it is empty or the held one advances
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid)
			byte_s1 <= rx_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_length_q <= pdas_pkg::MAX_LENGTH_RESET;
		end else if (cfg_wr_en) begin
			max_length_q <= cfg_wr_data;
		end
	end

	pdas_fsm u_fsm (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.rx_byte    (byte_s1),
		.max_length (max_length_q),
		.res        (res)
	);

	// result register: load on every advance (header bytes leave an empty
	// slot), drop the result once transferred out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_q <= '0;
		end else if (advance) begin
			if (res.valid)
				out_q <= res;
			else
				out_q.valid <= 1'b0;
		end else if (!out_stall) begin
			out_q.valid <= 1'b0;
		end
	end

	assign out_valid      = out_q.valid;
	assign kind           = out_q.kind;
	assign data_byte      = out_q.data_byte;
	assign is_last_packet = out_q.is_last_packet;
	assign sequence_res   = out_q.sequence_res;
	assign payload_length = out_q.payload_length;
	assign status         = out_q.status;

endmodule
